### sv/barometric_pressure_compensation_top_macros.svh
// Assertion macros shared by the compensation checker.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// next-cycle implication
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### sv/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Shared widths, register codes, constants and helpers; no dependencies.
`default_nettype none
package bpc_pkg;

  localparam int DW = 32;
  localparam int AW = 5;

  typedef enum logic [2:0] {
    REG_A1A2 = 3'd0,
    REG_A3A4 = 3'd1,
    REG_A5A6 = 3'd2,
    REG_B1B2 = 3'd3,
    REG_MCMD = 3'd4,
    REG_OSS  = 3'd5
  } reg_idx_t;

  localparam logic [DW-1:0] K_B6   = 32'd4000;
  localparam logic [DW-1:0] K_C1   = 32'd3038;
  localparam logic [DW-1:0] K_C2   = 32'hFFFF_E343; // -7357
  localparam logic [DW-1:0] K_C3   = 32'd3791;
  localparam logic [DW-1:0] K_F50K = 32'd50000;
  localparam logic [DW-1:0] K_HALF = 32'd32768;

  function automatic logic [DW-1:0] sx16(input logic [15:0] v);
    sx16 = {{(DW-16){v[15]}}, v};
  endfunction

  function automatic logic [DW-1:0] zx16(input logic [15:0] v);
    zx16 = {{(DW-16){1'b0}}, v};
  endfunction

endpackage
`default_nettype wire

### sv/bpc_if.sv
// Valid/ready channel interfaces for raw readings and compensated results.
// Standalone; no package dependency.
`default_nettype none
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_pa;
  logic signed [15:0] temperature_decidegrees;
  logic               divide_error;
  modport source (output valid, pressure_pa, temperature_decidegrees, divide_error,
                  input ready);
  modport sink (input valid, pressure_pa, temperature_decidegrees, divide_error,
                output ready);
endinterface
`default_nettype wire

### sv/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg; carries a sideband vector alongside each transaction.
`default_nettype none
module bpc_div #(
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [bpc_pkg::DW-1:0] num,
  input  logic [bpc_pkg::DW-1:0] den,
  input  logic [SW-1:0]          sb,
  output logic                   out_valid,
  output logic [bpc_pkg::DW-1:0] quo,
  output logic [SW-1:0]          out_sb
);
  import bpc_pkg::*;

  logic [DW-1:0] rem_r [DW];
  logic [DW-1:0] num_r [DW];
  logic [DW-1:0] den_r [DW];
  logic [DW-1:0] quo_r [DW];
  logic [SW-1:0] sb_r  [DW];
  logic          v_r   [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0] rem_p, num_p, den_p, quo_p;
    logic [SW-1:0] sb_p;
    logic          v_p;
    logic [DW:0]   trial, diff;
    logic [DW-1:0] rem_nxt;
    logic          bit_nxt;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign num_p = num;
      assign den_p = den;
      assign quo_p = '0;
      assign sb_p  = sb;
      assign v_p   = in_valid;
    end else begin : g_rest
      assign rem_p = rem_r[k-1];
      assign num_p = num_r[k-1];
      assign den_p = den_r[k-1];
      assign quo_p = quo_r[k-1];
      assign sb_p  = sb_r[k-1];
      assign v_p   = v_r[k-1];
    end

    always_comb begin
      trial   = {rem_p, num_p[DW-1]};
      diff    = trial - {1'b0, den_p};
      bit_nxt = !diff[DW];
      rem_nxt = bit_nxt ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= {num_p[DW-2:0], 1'b0};
        den_r[k] <= den_p;
        quo_r[k] <= {quo_p[DW-2:0], bit_nxt};
        sb_r[k]  <= sb_p;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign quo       = quo_r[DW-1];
  assign out_sb    = sb_r[DW-1];
endmodule
`default_nettype wire

### sv/barometric_pressure_compensation_top.sv
// Barometric pressure compensation, top level.
// Depends on bpc_pkg, bpc_if and bpc_div.
//
//   channel   kind          payload
//   in_if     valid/ready   raw_temperature, raw_pressure
//   out_if    valid/ready   pressure_pa, temperature_decidegrees, divide_error
//   cfg       APB write/rd  six calibration and oversampling registers
//
// Accepts one transaction per cycle while the output register is not stalled;
// the path is the two 32-stage divider pipelines plus eleven arithmetic stages.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-low reset clears valid bits and configuration.
`default_nettype none
module barometric_pressure_compensation_top (
  input  logic                   clk,
  input  logic                   rst_n,
  bpc_in_if.sink                 in_if,
  bpc_out_if.source              out_if,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [bpc_pkg::AW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import bpc_pkg::*;

  localparam int SWA = 19 + DW + 2;
  localparam int SWB = DW + 2;

  logic [31:0] a1a2_r, a3a4_r, a5a6_r, b1b2_r, mcmd_r;
  logic [1:0]  oss_r;
  logic [DW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1a2_r <= '0;
      a3a4_r <= '0;
      a5a6_r <= '0;
      b1b2_r <= '0;
      mcmd_r <= '0;
      oss_r  <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[AW-1:2]))
        REG_A1A2: a1a2_r <= pwdata;
        REG_A3A4: a3a4_r <= pwdata;
        REG_A5A6: a5a6_r <= pwdata;
        REG_B1B2: b1b2_r <= pwdata;
        REG_MCMD: mcmd_r <= pwdata;
        REG_OSS:  oss_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[AW-1:2]))
      REG_A1A2: prdata = a1a2_r;
      REG_A3A4: prdata = a3a4_r;
      REG_A5A6: prdata = a5a6_r;
      REG_B1B2: prdata = b1b2_r;
      REG_MCMD: prdata = mcmd_r;
      REG_OSS:  prdata = {30'd0, oss_r};
      default:  prdata = '0;
    endcase
  end

  assign ac1 = sx16(a1a2_r[15:0]);
  assign ac2 = sx16(a1a2_r[31:16]);
  assign ac3 = sx16(a3a4_r[15:0]);
  assign ac4 = zx16(a3a4_r[31:16]);
  assign ac5 = zx16(a5a6_r[15:0]);
  assign ac6 = zx16(a5a6_r[31:16]);
  assign b1  = sx16(b1b2_r[15:0]);
  assign b2  = sx16(b1b2_r[31:16]);
  assign mc  = sx16(mcmd_r[15:0]);
  assign md  = sx16(mcmd_r[31:16]);

  logic out_valid_r;
  logic adv;
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = adv;

  // stage 1: first temperature term
  logic          v1_r;
  logic [DW-1:0] x1_1_r, x1_1_nxt;
  logic [18:0]   up1_r;
  always_comb begin
    logic [DW-1:0] d;
    d        = zx16(in_if.raw_temperature) - ac6;
    x1_1_nxt = DW'($signed(d * ac5) >>> 15);
  end

  // stage 2: divider A operands
  logic          v2_r, neg2_r, err2_r;
  logic [DW-1:0] ma2_r, mb2_r, x1_2_r;
  logic [18:0]   up2_r;
  logic [DW-1:0] ma2_nxt, mb2_nxt;
  logic          neg2_nxt, err2_nxt;
  always_comb begin
    logic [DW-1:0] dv, nm;
    dv       = x1_1_r + md;
    nm       = {mc[DW-12:0], 11'd0};
    err2_nxt = (dv == '0);
    neg2_nxt = nm[DW-1] ^ dv[DW-1];
    ma2_nxt  = nm[DW-1] ? DW'(0) - nm : nm;
    mb2_nxt  = dv[DW-1] ? DW'(0) - dv : dv;
  end

  logic          va_o;
  logic [DW-1:0] qa;
  logic [SWA-1:0] sba_o;
  bpc_div #(.SW(SWA)) u_div_a (
    .clk, .rst_n, .en(adv), .in_valid(v2_r), .num(ma2_r), .den(mb2_r),
    .sb({up2_r, x1_2_r, neg2_r, err2_r}),
    .out_valid(va_o), .quo(qa), .out_sb(sba_o)
  );

  // stage 3: B5, B6
  logic          v3_r, err3_r;
  logic [DW-1:0] b5_3_r, b6_3_r, b5_3_nxt;
  logic [18:0]   up3_r;
  always_comb begin
    logic [DW-1:0] x2;
    x2       = sba_o[1] ? DW'(0) - qa : qa;
    b5_3_nxt = sba_o[DW+1:2] + x2;
  end

  // stage 4: products with B6
  logic          v4_r, err4_r;
  logic [DW-1:0] b5_4_r, sq4_r, a2_4_r, a3_4_r;
  logic [18:0]   up4_r;

  // stage 5: products with the square term
  logic          v5_r, err5_r;
  logic [DW-1:0] b5_5_r, x1_5_r, x2_5_r, a2_5_r, a3_5_r;
  logic [18:0]   up5_r;

  // stage 6: B3 and the B4 factor
  logic          v6_r, err6_r;
  logic [DW-1:0] b5_6_r, b3_6_r, x3_6_r, b3_6_nxt, x3_6_nxt;
  logic [18:0]   up6_r;
  always_comb begin
    logic [DW-1:0] x3, vv;
    x3       = x1_5_r + a2_5_r;
    vv       = (({ac1[DW-3:0], 2'd0} + x3) << oss_r) + DW'(2);
    b3_6_nxt = DW'($signed(vv + (vv[DW-1] ? DW'(3) : DW'(0))) >>> 2);
    x3_6_nxt = DW'($signed(a3_5_r + x2_5_r + DW'(2)) >>> 2);
  end

  // stage 7: B4 and UP - B3
  logic          v7_r, err7_r;
  logic [DW-1:0] b5_7_r, b4_7_r, d7_r;

  // stage 8: B7
  logic          v8_r, err8_r;
  logic [DW-1:0] b5_8_r, b4_8_r, b7_8_r;

  logic          hi8;
  logic [DW-1:0] numb;
  assign hi8  = b7_8_r[DW-1];
  assign numb = hi8 ? b7_8_r : {b7_8_r[DW-2:0], 1'b0};

  logic           vb_o;
  logic [DW-1:0]  qb;
  logic [SWB-1:0] sbb_o;
  bpc_div #(.SW(SWB)) u_div_b (
    .clk, .rst_n, .en(adv), .in_valid(v8_r), .num(numb), .den(b4_8_r),
    .sb({b5_8_r, hi8, err8_r}),
    .out_valid(vb_o), .quo(qb), .out_sb(sbb_o)
  );

  // stage 10: pressure square and linear terms
  logic          v10_r, err10_r;
  logic [DW-1:0] b5_10_r, p10_r, sq10_r, xb10_r, p10_nxt, sq10_nxt;
  always_comb begin
    logic [DW-1:0] t8;
    p10_nxt  = sbb_o[1] ? {qb[DW-2:0], 1'b0} : qb;
    t8       = DW'($signed(p10_nxt) >>> 8);
    sq10_nxt = t8 * t8;
  end

  // stage 11: quadratic term
  logic          v11_r, err11_r;
  logic [DW-1:0] b5_11_r, p11_r, xa11_r, xb11_r;

  // stage 12: output register
  logic [DW-1:0] pf_nxt, t_nxt;
  logic [15:0]   ts_nxt;
  logic [DW-1:0] pout_r;
  logic [15:0]   tout_r;
  logic          eout_r;
  always_comb begin
    pf_nxt = p11_r + DW'($signed(xa11_r + xb11_r + K_C3) >>> 4);
    t_nxt  = DW'($signed(b5_11_r + DW'(8)) >>> 4);
    if ($signed(t_nxt) < $signed(32'hFFFF_8000)) begin
      ts_nxt = 16'h8000;
    end else if ($signed(t_nxt) > $signed(32'h0000_7FFF)) begin
      ts_nxt = 16'h7FFF;
    end else begin
      ts_nxt = t_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v10_r <= 1'b0; v11_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_if.valid; v2_r <= v1_r; v3_r <= va_o; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      v10_r <= vb_o; v11_r <= v10_r; out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_1_r <= x1_1_nxt;
      up1_r  <= in_if.raw_pressure;

      ma2_r  <= ma2_nxt;
      mb2_r  <= mb2_nxt;
      neg2_r <= neg2_nxt;
      err2_r <= err2_nxt;
      x1_2_r <= x1_1_r;
      up2_r  <= up1_r;

      b5_3_r <= b5_3_nxt;
      b6_3_r <= b5_3_nxt - K_B6;
      up3_r  <= sba_o[SWA-1:DW+2];
      err3_r <= sba_o[0];

      sq4_r  <= DW'($signed(b6_3_r * b6_3_r) >>> 12);
      a2_4_r <= DW'($signed(ac2 * b6_3_r) >>> 11);
      a3_4_r <= DW'($signed(ac3 * b6_3_r) >>> 13);
      b5_4_r <= b5_3_r;
      up4_r  <= up3_r;
      err4_r <= err3_r;

      x1_5_r <= DW'($signed(b2 * sq4_r) >>> 11);
      x2_5_r <= DW'($signed(b1 * sq4_r) >>> 16);
      a2_5_r <= a2_4_r;
      a3_5_r <= a3_4_r;
      b5_5_r <= b5_4_r;
      up5_r  <= up4_r;
      err5_r <= err4_r;

      b3_6_r <= b3_6_nxt;
      x3_6_r <= x3_6_nxt;
      b5_6_r <= b5_5_r;
      up6_r  <= up5_r;
      err6_r <= err5_r;

      b4_7_r <= (ac4 * (x3_6_r + K_HALF)) >> 15;
      d7_r   <= {{(DW-19){1'b0}}, up6_r} - b3_6_r;
      b5_7_r <= b5_6_r;
      err7_r <= err6_r;

      b7_8_r <= d7_r * (K_F50K >> oss_r);
      b4_8_r <= b4_7_r;
      b5_8_r <= b5_7_r;
      err8_r <= err7_r || (b4_7_r == '0);

      p10_r   <= p10_nxt;
      sq10_r  <= sq10_nxt;
      xb10_r  <= DW'($signed(K_C2 * p10_nxt) >>> 16);
      b5_10_r <= sbb_o[SWB-1:2];
      err10_r <= sbb_o[0];

      xa11_r  <= DW'($signed(sq10_r * K_C1) >>> 16);
      xb11_r  <= xb10_r;
      p11_r   <= p10_r;
      b5_11_r <= b5_10_r;
      err11_r <= err10_r;

      pout_r <= err11_r ? '0 : pf_nxt;
      tout_r <= err11_r ? '0 : ts_nxt;
      eout_r <= err11_r;
    end
  end

  assign out_if.valid                   = out_valid_r;
  assign out_if.pressure_pa             = $signed(pout_r);
  assign out_if.temperature_decidegrees = $signed(tout_r);
  assign out_if.divide_error            = eout_r;
endmodule
`default_nettype wire

### sv/bpc_checker.sv
// Port-level checker for the compensation top level, bound to it below.
// Depends on barometric_pressure_compensation_top_macros.svh.
`default_nettype none
`include "barometric_pressure_compensation_top_macros.svh"
module bpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pressure_pa,
  input logic [15:0] temperature_decidegrees,
  input logic        divide_error
);
  `BPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pressure_pa) && $stable(temperature_decidegrees) && $stable(divide_error))
  `BPC_ASSERT_NOW(a_err_zero, out_valid && divide_error, pressure_pa == 32'd0 && temperature_decidegrees == 16'd0)
  `BPC_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready)
  `BPC_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)
endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_ready                (in_if.ready),
  .out_valid               (out_if.valid),
  .out_ready               (out_if.ready),
  .pressure_pa             (out_if.pressure_pa),
  .temperature_decidegrees (out_if.temperature_decidegrees),
  .divide_error            (out_if.divide_error)
);
`default_nettype wire
